[hw/rtl/fbpse_pkg.sv]
// Shared command codes, register indexes, widths and control/status types for the pixel engine.
package fbpse_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam int CFG_W = 7;                // width of a dimension register
	localparam int PROD_W = 2 * CFG_W;       // width of a dimension product
	localparam int CMP_W = 9;                // wide enough to compare a dimension to a maximum

	localparam logic [2:0] CMD_WRITE  = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_CLEAR  = 3'd2;
	localparam logic [2:0] CMD_LEFT   = 3'd3;
	localparam logic [2:0] CMD_RIGHT  = 3'd4;
	localparam logic [2:0] CMD_UP     = 3'd5;
	localparam logic [2:0] CMD_DOWN   = 3'd6;
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic capture;     // latch the incoming transaction
		logic mul_prod;    // register width times (row or height)
		logic mul_off;     // register the shift offset
		logic walk_start;  // load the walk counters
		logic walk_step;   // advance the walk counters
		logic pix_go;      // single pixel read or write
		logic rd_go;       // read the source pixel of a shift
		logic wr_go;       // write the destination pixel of a walk
		logic out_load;    // load the result register
	} ctl_cmd_t;

	typedef struct packed {
		logic is_pix;
		logic bad;
		logic clear_op;
		logic wh_zero;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

[hw/rtl/fbpse_dp.sv]
// Datapath of the pixel engine: item and config registers, pixel store, walk counters, result.
module fbpse_dp #(
	parameter int MAX_WIDTH  = fbpse_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = fbpse_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fbpse_pkg::ctl_cmd_t             ctl,
	output fbpse_pkg::dp_stat_t             stat,
	input  logic [2:0]                      cmd,
	input  logic signed [7:0]               col,
	input  logic signed [7:0]               row,
	input  logic [7:0]                      pixel_in,
	input  logic signed [7:0]               shift_amount,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            status,
	output logic [7:0]                      pixel_out,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [0:0]                      cfg_index,
	input  logic [fbpse_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CW    = fbpse_pkg::CFG_W;
	localparam int PW    = fbpse_pkg::PROD_W;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = ((AW > PW) ? AW : PW) + 1;

	logic [CW-1:0] width_q, height_q;
	logic [CW-1:0] w_eff, h_eff;

	logic [2:0]        cmd_q;
	logic signed [7:0] col_q, row_q, shamt_q;
	logic [7:0]        pix_in_q;
	logic [CW-1:0]     n7;

	logic [PW-1:0] prod_q, off_q, product;
	logic [CW-1:0] mul_a;

	logic [AW-1:0] d_q, lim_q, d_first;
	logic [CW-1:0] r_q, c_q;
	logic          dir_q, clr_mode_q;

	logic is_pix, is_shift, is_vert, pix_bad, shift_bad, far_shift, bad, clear_op, fill;
	logic [AW-1:0] pix_addr, src_addr, waddr, raddr;
	logic [XW-1:0] src_x;
	logic [7:0]    wdata, rdata_q;
	logic          mem_we, mem_re;
	logic [7:0]    mem [DEPTH];

	logic       out_valid_q, status_q;
	logic [7:0] pixel_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CW'(5);
			height_q <= CW'(5);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fbpse_pkg::REG_WIDTH:  width_q  <= cfg_data;
				fbpse_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Dimensions beyond the store are clamped to its maximum.
	always_comb begin
		w_eff = width_q;
		h_eff = height_q;
		if (fbpse_pkg::CMP_W'(width_q) > fbpse_pkg::CMP_W'(MAX_WIDTH))
			w_eff = CW'(MAX_WIDTH);
		if (fbpse_pkg::CMP_W'(height_q) > fbpse_pkg::CMP_W'(MAX_HEIGHT))
			h_eff = CW'(MAX_HEIGHT);
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= cmd;
			col_q    <= col;
			row_q    <= row;
			pix_in_q <= pixel_in;
			shamt_q  <= shift_amount;
		end
	end

	assign n7 = shamt_q[CW-1:0];

	always_comb begin
		is_pix    = cmd_q inside {fbpse_pkg::CMD_WRITE, fbpse_pkg::CMD_READ};
		is_shift  = cmd_q inside {fbpse_pkg::CMD_LEFT, fbpse_pkg::CMD_RIGHT,
			fbpse_pkg::CMD_UP, fbpse_pkg::CMD_DOWN};
		is_vert   = cmd_q inside {fbpse_pkg::CMD_UP, fbpse_pkg::CMD_DOWN};
		pix_bad   = col_q[7] || row_q[7] || (col_q[CW-1:0] >= w_eff) ||
			(row_q[CW-1:0] >= h_eff);
		shift_bad = shamt_q[7] || (shamt_q == 8'sd0);
		far_shift = is_shift && !shift_bad && (is_vert ? (n7 >= h_eff) : (n7 >= w_eff));
		bad       = (is_pix && pix_bad) || (is_shift && shift_bad) ||
			(cmd_q == fbpse_pkg::CMD_UNUSED);
		clear_op  = (cmd_q == fbpse_pkg::CMD_CLEAR) || far_shift;
	end

	// One shared multiplier: row or height times width in setup, shift times width after.
	assign mul_a   = ctl.mul_off ? n7 : (is_pix ? row_q[CW-1:0] : h_eff);
	assign product = PW'(mul_a) * PW'(w_eff);

	always_ff @(posedge clk) begin
		if (ctl.mul_prod)
			prod_q <= product;
		if (ctl.mul_off)
			off_q <= is_vert ? product : PW'(n7);
	end

	assign d_first = AW'(XW'(prod_q) - XW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q        <= '0;
			lim_q      <= AW'(DEPTH - 1);
			r_q        <= '0;
			c_q        <= '0;
			dir_q      <= 1'b0;
			clr_mode_q <= 1'b1;
		end else if (ctl.walk_start) begin
			dir_q      <= !clear_op && ((cmd_q == fbpse_pkg::CMD_RIGHT) ||
				(cmd_q == fbpse_pkg::CMD_DOWN));
			clr_mode_q <= clear_op;
			lim_q      <= d_first;
			if (!clear_op && ((cmd_q == fbpse_pkg::CMD_RIGHT) ||
				(cmd_q == fbpse_pkg::CMD_DOWN))) begin
				d_q <= d_first;
				r_q <= h_eff - CW'(1);
				c_q <= w_eff - CW'(1);
			end else begin
				d_q <= '0;
				r_q <= '0;
				c_q <= '0;
			end
		end else if (ctl.walk_step) begin
			if (dir_q) begin
				d_q <= d_q - AW'(1);
				if (c_q == '0) begin
					c_q <= w_eff - CW'(1);
					r_q <= r_q - CW'(1);
				end else begin
					c_q <= c_q - CW'(1);
				end
			end else begin
				d_q <= d_q + AW'(1);
				if (c_q == w_eff - CW'(1)) begin
					c_q <= '0;
					r_q <= r_q + CW'(1);
				end else begin
					c_q <= c_q + CW'(1);
				end
			end
		end
	end

	// Pixels vacated by the shift take zero instead of a source pixel.
	always_comb begin
		case (cmd_q)
			fbpse_pkg::CMD_LEFT:  fill = ({1'b0, c_q} + {1'b0, n7}) >= {1'b0, w_eff};
			fbpse_pkg::CMD_RIGHT: fill = c_q < n7;
			fbpse_pkg::CMD_UP:    fill = ({1'b0, r_q} + {1'b0, n7}) >= {1'b0, h_eff};
			fbpse_pkg::CMD_DOWN:  fill = r_q < n7;
			default:              fill = 1'b0;
		endcase
	end

	assign src_x    = dir_q ? (XW'(d_q) - XW'(off_q)) : (XW'(d_q) + XW'(off_q));
	assign src_addr = AW'(src_x);
	assign pix_addr = AW'(XW'(prod_q) + XW'(col_q[CW-1:0]));

	assign waddr  = ctl.pix_go ? pix_addr : d_q;
	assign raddr  = ctl.pix_go ? pix_addr : src_addr;
	assign wdata  = ctl.pix_go ? pix_in_q : ((clr_mode_q || fill) ? 8'd0 : rdata_q);
	assign mem_we = ctl.wr_go || (ctl.pix_go && (cmd_q == fbpse_pkg::CMD_WRITE));
	assign mem_re = (ctl.rd_go && !fill) || (ctl.pix_go && (cmd_q == fbpse_pkg::CMD_READ));

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status_q <= bad;
			pixel_q  <= ((cmd_q == fbpse_pkg::CMD_READ) && !bad) ? rdata_q : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pixel_out = pixel_q;

	always_comb begin
		stat.is_pix   = is_pix;
		stat.bad      = bad;
		stat.clear_op = clear_op;
		stat.wh_zero  = (prod_q == '0);
		stat.last     = dir_q ? (d_q == '0) : (d_q == lim_q);
		stat.out_free = !out_valid_q || !out_stall;
	end

endmodule

[hw/rtl/fbpse_ctrl.sv]
// Controller state machine of the pixel engine: sequences setup, pixel access and store walks.
module fbpse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  fbpse_pkg::dp_stat_t stat,
	output fbpse_pkg::ctl_cmd_t ctl
);

	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_SETUP  = 4'd2;
	localparam logic [3:0] ST_SETUP2 = 4'd3;
	localparam logic [3:0] ST_PIX    = 4'd4;
	localparam logic [3:0] ST_RD     = 4'd5;
	localparam logic [3:0] ST_WR     = 4'd6;
	localparam logic [3:0] ST_CLR    = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0] state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_INIT;
		else
			state_q <= state_nx;
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		case (state_q)
			ST_INIT: begin
				ctl.wr_go     = 1'b1;
				ctl.walk_step = 1'b1;
				if (stat.last)
					state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_nx    = ST_SETUP;
				end
			end
			ST_SETUP: begin
				ctl.mul_prod = 1'b1;
				if (stat.bad)
					state_nx = ST_DONE;
				else if (stat.is_pix)
					state_nx = ST_PIX;
				else
					state_nx = ST_SETUP2;
			end
			ST_SETUP2: begin
				ctl.mul_off = 1'b1;
				if (stat.wh_zero) begin
					state_nx = ST_DONE;
				end else begin
					ctl.walk_start = 1'b1;
					state_nx = stat.clear_op ? ST_CLR : ST_RD;
				end
			end
			ST_PIX: begin
				ctl.pix_go = 1'b1;
				state_nx   = ST_DONE;
			end
			ST_RD: begin
				ctl.rd_go = 1'b1;
				state_nx  = ST_WR;
			end
			ST_WR: begin
				ctl.wr_go     = 1'b1;
				ctl.walk_step = 1'b1;
				state_nx      = stat.last ? ST_DONE : ST_RD;
			end
			ST_CLR: begin
				ctl.wr_go     = 1'b1;
				ctl.walk_step = 1'b1;
				if (stat.last)
					state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/framebuffer_pixel_shift_engine.sv]
// Top level of the framebuffer pixel shift engine: controller plus datapath.
//
// The engine keeps an 8-bit grayscale image of up to MAX_WIDTH by MAX_HEIGHT pixels in a
// single-ported on-chip store, laid out row by row with the configured width as the stride.
// Each input transaction carries one command (write pixel, read pixel, clear, or shift left,
// right, up or down) and produces exactly one result transaction with a status bit (1 means
// an out-of-range coordinate, a non-positive shift or the unused command code) and the pixel
// read, which is zero for every other command and for failed reads. Shifts fill the vacated
// pixels with zero, and a shift at or beyond the image dimension simply clears the image.
// The user must write width and height through the configuration port only while the engine is
// idle; the block itself does not enforce this. Values above the maximum are treated as the
// maximum, and changing them reinterprets the stored pixels rather than moving them. Items are
// handled one at a time. A pixel write or read passes through setup, pixel access and result.
// Clear, and a shift that clears, pass through setup, one write per pixel and result; a real
// shift has a read step and a write step per pixel, as the single memory port is shared. A
// failed command goes from setup to result. After reset the engine first zeroes the whole store
// of MAX_WIDTH*MAX_HEIGHT entries (4096 with the defaults), one entry per cycle, holding in_stall
// high meanwhile; configuration writes are taken at any time. A finished result waits in an
// output register, and the engine accepts the next input transaction while it is still stalled.
module framebuffer_pixel_shift_engine #(
	parameter int MAX_WIDTH  = fbpse_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = fbpse_pkg::MAX_HEIGHT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Command channel.
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  cmd,
	input  logic signed [7:0]           col,
	input  logic signed [7:0]           row,
	input  logic [7:0]                  pixel_in,
	input  logic signed [7:0]           shift_amount,
	// Result channel.
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [7:0]                  pixel_out,
	// Configuration write channel: index 0 is the image width, index 1 the image height.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [fbpse_pkg::CFG_W-1:0] cfg_data
);

	// The controller only issues commands and watches status; all data storage sits in the datapath.
	fbpse_pkg::ctl_cmd_t ctl;
	fbpse_pkg::dp_stat_t stat;

	fbpse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	fbpse_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (cmd),
		.col          (col),
		.row          (row),
		.pixel_in     (pixel_in),
		.shift_amount (shift_amount),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.pixel_out    (pixel_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

endmodule
